[hw/rtl/lldpx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lldpx_pkg
// Types, TLV codes and result builders shared by the LLDP neighbor extractor.
// ----------------------------------------------------------------------------
package lldpx_pkg;

  // ethernet header bytes in front of the first TLV
  localparam logic [15:0] ETH_HDR_LEN = 16'd14;

  // TLV type codes
  localparam logic [6:0] TLV_END       = 7'h00;
  localparam logic [6:0] TLV_PORT_ID   = 7'h02;
  localparam logic [6:0] TLV_PORT_DESC = 7'h04;
  localparam logic [6:0] TLV_SYS_NAME  = 7'h05;
  localparam logic [6:0] TLV_ORG       = 7'h7F;

  // port id subtype that clears the port
  localparam logic [7:0] PORT_SUBTYPE_LOCAL = 8'h07;

  // organizational prefixes: oui and subtype
  localparam logic [31:0] ORG_VLAN_ID = 32'h0080_C201;
  localparam logic [31:0] ORG_MED_HW  = 32'h0012_BB0A;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_HI,
    PH_LO,
    PH_VAL,
    PH_STOP,
    PH_IDLE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    TGT_HOST = 2'd0,
    TGT_PORT = 2'd1,
    TGT_PLAT = 2'd2
  } target_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_len;
    logic        frame_start;
  } in_beat_t;

  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } in_stage_t;

  typedef struct packed {
    kind_e       kind;
    target_e     target;
    logic [4:0]  char_index;
    logic [7:0]  char_value;
    logic [4:0]  str_length;
    logic [15:0] vlan_id;
    logic        vlan_present;
    logic        valid_res;
    logic        last_of_run;
  } res_row_t;

  typedef struct packed {
    logic [1:0]         cnt;
    res_row_t [2:0]     rows;
  } res_bundle_t;

  function automatic res_row_t mk_write(target_e tgt, logic [4:0] idx, logic [7:0] val);
    res_row_t r;
    r            = '0;
    r.kind       = KIND_WRITE;
    r.target     = tgt;
    r.char_index = idx;
    r.char_value = val;
    return r;
  endfunction

  function automatic res_row_t mk_commit(target_e tgt, logic [4:0] len);
    res_row_t r;
    r            = '0;
    r.kind       = KIND_COMMIT;
    r.target     = tgt;
    r.str_length = len;
    return r;
  endfunction

  function automatic res_row_t mk_summary(logic [15:0] vid, logic vpres, logic vres);
    res_row_t r;
    r              = '0;
    r.kind         = KIND_SUMMARY;
    r.target       = TGT_HOST;
    r.vlan_id      = vid;
    r.vlan_present = vpres;
    r.valid_res    = vres;
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/lldpx_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lldpx_if
// Valid/ready channels for frame bytes in and neighbor results out.
// ----------------------------------------------------------------------------
interface lldpx_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] frame_len;
  logic        frame_start;

  modport source (output valid, data_byte, frame_len, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_len, frame_start, output ready);
endinterface

interface lldpx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  target;
  logic [4:0]  char_index;
  logic [7:0]  char_value;
  logic [4:0]  str_length;
  logic [15:0] vlan_id;
  logic        vlan_present;
  logic        valid_res;
  logic        last_of_run;

  modport source (output valid, kind, target, char_index, char_value, str_length,
                  vlan_id, vlan_present, valid_res, last_of_run, input ready);
  modport sink   (input valid, kind, target, char_index, char_value, str_length,
                  vlan_id, vlan_present, valid_res, last_of_run, output ready);
endinterface
`default_nettype wire

[hw/rtl/lldp_tlv_neighbor_extractor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lldp_tlv_neighbor_extractor
// Streaming LLDP parser: extracts system name, port, platform and VLAN id.
// ----------------------------------------------------------------------------
// channel  dir  beat                                     accept
// in_i     in   data_byte, frame_len, frame_start        valid && ready
// res_o    out  kind, target, char_index, char_value,    valid && ready
//               str_length, vlan_id, vlan_present,
//               valid_res, last_of_run
//
// one byte per cycle when each byte yields at most one result row; a byte
// that yields n rows keeps the result register until its rows drain, so the
// input stalls until the last of them is leaving.
// an accepted byte waits in the input register and is decoded into the result
// register once that can load; its rows leave from there.
// reset clears the walker state and both valid flags; no clearing pass.
// a stalled res_o backs up through the result register into the input one.
// ----------------------------------------------------------------------------
module lldp_tlv_neighbor_extractor
  import lldpx_pkg::*;
#(
  parameter int unsigned STRING_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lldpx_in_if.sink    in_i,
  lldpx_out_if.source res_o
);

  in_beat_t    in_beat;
  in_stage_t   stage;
  logic        take;
  logic        can_load;
  res_bundle_t bundle;
  res_row_t    head;

  assign in_beat.data_byte   = in_i.data_byte;
  assign in_beat.frame_len   = in_i.frame_len;
  assign in_beat.frame_start = in_i.frame_start;

  assign take = stage.valid && can_load;

  lldpx_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_beat_i  (in_beat),
    .take_i     (take),
    .in_ready_o (in_i.ready),
    .stage_o    (stage)
  );

  lldpx_parser #(
    .STRING_LEN (STRING_LEN)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (take),
    .beat_i   (stage.beat),
    .bundle_o (bundle)
  );

  lldpx_res_queue u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .bundle_i    (bundle),
    .out_ready_i (res_o.ready),
    .can_load_o  (can_load),
    .out_valid_o (res_o.valid),
    .head_o      (head)
  );

  assign res_o.kind         = head.kind;
  assign res_o.target       = head.target;
  assign res_o.char_index   = head.char_index;
  assign res_o.char_value   = head.char_value;
  assign res_o.str_length   = head.str_length;
  assign res_o.vlan_id      = head.vlan_id;
  assign res_o.vlan_present = head.vlan_present;
  assign res_o.valid_res    = head.valid_res;
  assign res_o.last_of_run  = head.last_of_run;

`ifndef SYNTH
  a_summary_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == KIND_SUMMARY)) |-> res_o.last_of_run)
    else $error("summary row not marked last of its run");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !res_o.last_of_run) |=> res_o.valid)
    else $error("result run broken before its last row");

  a_string_rows_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind != KIND_SUMMARY)) |->
      ((res_o.vlan_id == 16'd0) && !res_o.vlan_present && !res_o.valid_res))
    else $error("string row carries summary fields");
`endif

endmodule
`default_nettype wire

[hw/rtl/lldpx_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lldpx_in_stage
// Input register: holds one frame byte until the parser takes it.
// ----------------------------------------------------------------------------
module lldpx_in_stage
  import lldpx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_beat_t  in_beat_i,
  input  logic      take_i,
  output logic      in_ready_o,
  output in_stage_t stage_o
);

  logic     vld_q;
  logic     vld_d;
  in_beat_t beat_q;

  assign in_ready_o = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= in_beat_i;
    end
  end

  assign stage_o.valid = vld_q;
  assign stage_o.beat  = beat_q;

endmodule
`default_nettype wire

[hw/rtl/lldpx_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lldpx_parser
// Frame walker state and the single-pass decode of one byte into up to three
// result rows (character write, length commit, frame summary).
// ----------------------------------------------------------------------------
module lldpx_parser
  import lldpx_pkg::*;
#(
  parameter int unsigned STRING_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  in_beat_t    beat_i,
  output res_bundle_t bundle_o
);

  localparam logic [9:0] STR_MAX = 10'(STRING_LEN - 1);

  logic [15:0] pos_q, pos_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_hi_q, hdr_hi_d;
  logic [6:0]  cur_type_q, cur_type_d;
  logic [8:0]  remain_q, remain_d;
  logic [8:0]  offset_q, offset_d;
  logic [31:0] org_q, org_d;
  logic [7:0]  vlan_hi_q, vlan_hi_d;
  logic [15:0] vlan_q, vlan_d;
  logic        vlan_seen_q, vlan_seen_d;
  logic        found_q, found_d;
  logic        port_empty_q, port_empty_d;
  logic [15:0] flen_q, flen_d;

  // frame start restarts the walk before the byte is parsed
  logic        start;
  logic [7:0]  b;
  logic [15:0] s_pos;
  phase_e      s_phase;
  logic [7:0]  s_hdr_hi;
  logic [6:0]  s_type;
  logic [8:0]  s_rem;
  logic [8:0]  s_off;
  logic [31:0] s_org;
  logic [7:0]  s_vlan_hi;
  logic [15:0] s_vlan;
  logic        s_vlan_seen;
  logic        s_found;
  logic        s_port_empty;
  logic [15:0] s_flen;

  assign start        = beat_i.frame_start;
  assign b            = beat_i.data_byte;
  assign s_pos        = start ? 16'd0 : pos_q;
  assign s_phase      = start ? PH_SKIP : phase_q;
  assign s_hdr_hi     = start ? 8'd0 : hdr_hi_q;
  assign s_type       = start ? 7'd0 : cur_type_q;
  assign s_rem        = start ? 9'd0 : remain_q;
  assign s_off        = start ? 9'd0 : offset_q;
  assign s_org        = start ? 32'd0 : org_q;
  assign s_vlan_hi    = start ? 8'd0 : vlan_hi_q;
  assign s_vlan       = start ? 16'd0 : vlan_q;
  assign s_vlan_seen  = start ? 1'b0 : vlan_seen_q;
  assign s_found      = start ? 1'b0 : found_q;
  assign s_port_empty = start ? 1'b1 : port_empty_q;
  assign s_flen       = start ? beat_i.frame_len : flen_q;

  // shared decode
  logic        active;
  logic        in_frame;
  logic        frame_end;
  logic        at_lo;
  logic        at_val;
  logic [6:0]  hdr_type;
  logic [8:0]  hdr_len;
  logic        hdr_stop;
  logic [9:0]  vlen;
  logic        val_last;
  logic [31:0] org_new;
  logic        port_local;
  logic        org_ok;
  logic        is_vlan;
  logic        is_med;

  assign active    = fire_i && (s_phase != PH_IDLE);
  assign in_frame  = s_pos < s_flen;
  assign frame_end = ({1'b0, s_pos} + 17'd1) >= {1'b0, s_flen};
  assign at_lo     = active && in_frame && (s_phase == PH_LO);
  assign at_val    = active && in_frame && (s_phase == PH_VAL);
  assign hdr_type  = s_hdr_hi[7:1];
  assign hdr_len   = {s_hdr_hi[0], b};
  // tlv running past the frame end, or the end tlv
  assign hdr_stop  = (({2'b0, s_pos} + 18'd1 + {9'd0, hdr_len}) > {2'b0, s_flen})
                     || (hdr_type == TLV_END);
  assign vlen      = {1'b0, s_off} + {1'b0, s_rem};
  assign val_last  = (s_rem == 9'd1);

  // the first four value bytes build the oui/subtype prefix
  always_comb begin
    org_new = s_org;
    if (s_off[8:2] == 7'd0) begin
      case (s_off[1:0])
        2'd0:    org_new[31:24] = s_org[31:24] | b;
        2'd1:    org_new[23:16] = s_org[23:16] | b;
        2'd2:    org_new[15:8]  = s_org[15:8]  | b;
        default: org_new[7:0]   = s_org[7:0]   | b;
      endcase
    end
  end

  assign port_local = (org_new[31:24] == PORT_SUBTYPE_LOCAL);
  assign org_ok     = (vlen >= 10'd4) && (s_off >= 9'd3);
  assign is_vlan    = org_ok && (org_new == ORG_VLAN_ID) && (vlen >= 10'd6);
  assign is_med     = org_ok && (org_new == ORG_MED_HW);

  // next state
  always_comb begin
    pos_d        = s_pos;
    phase_d      = s_phase;
    hdr_hi_d     = s_hdr_hi;
    cur_type_d   = s_type;
    remain_d     = s_rem;
    offset_d     = s_off;
    org_d        = s_org;
    vlan_hi_d    = s_vlan_hi;
    vlan_d       = s_vlan;
    vlan_seen_d  = s_vlan_seen;
    found_d      = s_found;
    port_empty_d = s_port_empty;
    flen_d       = s_flen;
    if (active) begin
      if (in_frame) begin
        unique case (s_phase)
          PH_SKIP: begin
            if (s_pos >= (ETH_HDR_LEN - 16'd1)) begin
              phase_d = PH_HI;
            end
          end
          PH_HI: begin
            hdr_hi_d = b;
            phase_d  = PH_LO;
          end
          PH_LO: begin
            cur_type_d = hdr_type;
            if (hdr_stop) begin
              phase_d = PH_STOP;
            end else if (hdr_len == 9'd0) begin
              if (hdr_type == TLV_SYS_NAME) begin
                found_d = 1'b1;
              end
              phase_d = PH_HI;
            end else begin
              remain_d = hdr_len;
              offset_d = 9'd0;
              org_d    = 32'd0;
              phase_d  = PH_VAL;
            end
          end
          PH_VAL: begin
            org_d    = org_new;
            offset_d = s_off + 9'd1;
            remain_d = s_rem - 9'd1;
            unique case (s_type)
              TLV_SYS_NAME: begin
                if (val_last) begin
                  found_d = 1'b1;
                end
              end
              TLV_PORT_ID: begin
                if (port_local) begin
                  if (s_off == 9'd0) begin
                    port_empty_d = 1'b1;
                  end
                end else if (val_last) begin
                  found_d      = 1'b1;
                  port_empty_d = (vlen == 10'd1);
                end
              end
              TLV_PORT_DESC: begin
                if (s_port_empty && val_last) begin
                  port_empty_d = 1'b0;
                end
              end
              TLV_ORG: begin
                if (is_vlan) begin
                  if (s_off == 9'd4) begin
                    vlan_hi_d = b;
                  end
                  if (s_off == 9'd5) begin
                    vlan_d      = {s_vlan_hi, b};
                    vlan_seen_d = 1'b1;
                    found_d     = 1'b1;
                  end
                end else if (is_med && val_last) begin
                  found_d = 1'b1;
                end
              end
              default: ;
            endcase
            if (val_last) begin
              phase_d = PH_HI;
            end
          end
          default: ;
        endcase
      end
      if (frame_end) begin
        phase_d = PH_IDLE;
      end else begin
        pos_d = s_pos + 16'd1;
      end
    end
  end

  // result candidates
  logic       wr_en;
  target_e    wr_tgt;
  logic [9:0] wr_idx;
  logic       cm_en;
  target_e    cm_tgt;
  logic [9:0] cm_raw;
  logic       wr_ok;
  logic [9:0] cm_cap;
  logic       sum_en;

  always_comb begin
    wr_en  = 1'b0;
    wr_tgt = TGT_HOST;
    wr_idx = 10'd0;
    cm_en  = 1'b0;
    cm_tgt = TGT_HOST;
    cm_raw = 10'd0;
    if (at_lo && !hdr_stop && (hdr_len == 9'd0)) begin
      if (hdr_type == TLV_SYS_NAME) begin
        cm_en  = 1'b1;
        cm_tgt = TGT_HOST;
      end else if ((hdr_type == TLV_PORT_DESC) && s_port_empty) begin
        cm_en  = 1'b1;
        cm_tgt = TGT_PORT;
      end
    end
    if (at_val) begin
      unique case (s_type)
        TLV_SYS_NAME: begin
          wr_en  = 1'b1;
          wr_tgt = TGT_HOST;
          wr_idx = {1'b0, s_off};
          if (val_last) begin
            cm_en  = 1'b1;
            cm_tgt = TGT_HOST;
            cm_raw = vlen;
          end
        end
        TLV_PORT_ID: begin
          if (port_local) begin
            if (s_off == 9'd0) begin
              cm_en  = 1'b1;
              cm_tgt = TGT_PORT;
            end
          end else begin
            if (s_off != 9'd0) begin
              wr_en  = 1'b1;
              wr_tgt = TGT_PORT;
              wr_idx = {1'b0, s_off} - 10'd1;
            end
            if (val_last) begin
              cm_en  = 1'b1;
              cm_tgt = TGT_PORT;
              cm_raw = vlen - 10'd1;
            end
          end
        end
        TLV_PORT_DESC: begin
          if (s_port_empty) begin
            wr_en  = 1'b1;
            wr_tgt = TGT_PORT;
            wr_idx = {1'b0, s_off};
            if (val_last) begin
              cm_en  = 1'b1;
              cm_tgt = TGT_PORT;
              cm_raw = vlen;
            end
          end
        end
        TLV_ORG: begin
          if (!is_vlan && is_med) begin
            if (s_off >= 9'd4) begin
              wr_en  = 1'b1;
              wr_tgt = TGT_PLAT;
              wr_idx = {1'b0, s_off} - 10'd4;
            end
            if (val_last) begin
              cm_en  = 1'b1;
              cm_tgt = TGT_PLAT;
              cm_raw = vlen - 10'd4;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // characters past the string limit are dropped, lengths are clamped
  assign wr_ok  = wr_en && (wr_idx < STR_MAX);
  assign cm_cap = (cm_raw < STR_MAX) ? cm_raw : STR_MAX;
  assign sum_en = active && frame_end;

  // pack the rows in order write, commit, summary
  always_comb begin
    res_row_t   wr_row;
    res_row_t   cm_row;
    res_row_t   sm_row;
    logic [1:0] n;
    wr_row             = mk_write(wr_tgt, wr_idx[4:0], b);
    wr_row.last_of_run = !cm_en && !sum_en;
    cm_row             = mk_commit(cm_tgt, cm_cap[4:0]);
    cm_row.last_of_run = !sum_en;
    sm_row             = mk_summary(vlan_d, vlan_seen_d, found_d);
    sm_row.last_of_run = 1'b1;
    n                  = 2'd0;
    bundle_o.rows      = '0;
    if (wr_ok) begin
      bundle_o.rows[n] = wr_row;
      n                = n + 2'd1;
    end
    if (cm_en) begin
      bundle_o.rows[n] = cm_row;
      n                = n + 2'd1;
    end
    if (sum_en) begin
      bundle_o.rows[n] = sm_row;
      n                = n + 2'd1;
    end
    bundle_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 16'd0;
      phase_q      <= PH_SKIP;
      hdr_hi_q     <= 8'd0;
      cur_type_q   <= 7'd0;
      remain_q     <= 9'd0;
      offset_q     <= 9'd0;
      org_q        <= 32'd0;
      vlan_hi_q    <= 8'd0;
      vlan_q       <= 16'd0;
      vlan_seen_q  <= 1'b0;
      found_q      <= 1'b0;
      port_empty_q <= 1'b1;
      flen_q       <= 16'd0;
    end else if (fire_i) begin
      pos_q        <= pos_d;
      phase_q      <= phase_d;
      hdr_hi_q     <= hdr_hi_d;
      cur_type_q   <= cur_type_d;
      remain_q     <= remain_d;
      offset_q     <= offset_d;
      org_q        <= org_d;
      vlan_hi_q    <= vlan_hi_d;
      vlan_q       <= vlan_d;
      vlan_seen_q  <= vlan_seen_d;
      found_q      <= found_d;
      port_empty_q <= port_empty_d;
      flen_q       <= flen_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lldpx_res_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lldpx_res_queue
// Result register: holds the rows of one byte and hands them out one per beat.
// ----------------------------------------------------------------------------
module lldpx_res_queue
  import lldpx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_bundle_t bundle_i,
  input  logic        out_ready_i,
  output logic        can_load_o,
  output logic        out_valid_o,
  output res_row_t    head_o
);

  logic [1:0]     cnt_q, cnt_d;
  res_row_t [2:0] rows_q;

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = rows_q[0];
  // free when empty, or once the last waiting row leaves in this cycle
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = bundle_i.cnt;
    end else if (out_valid_o && out_ready_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rows_q <= bundle_i.rows;
    end else if (out_valid_o && out_ready_i) begin
      rows_q[0] <= rows_q[1];
      rows_q[1] <= rows_q[2];
    end
  end

endmodule
`default_nettype wire

[tb/sv/lldp_tlv_neighbor_extractor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lldp_tlv_neighbor_extractor_tb
// Streams LLDP frames into the extractor byte by byte with random gaps on the
// input and random stalls on the result side. A scoreboard walks every
// accepted byte through its own TLV walker and checks each result row in
// order. The stimulus covers short directed frames, then random frames built
// from well-formed TLVs, with noise, cut-off and overrun frames mixed in.
// ----------------------------------------------------------------------------
module lldp_tlv_neighbor_extractor_tb
  import lldpx_pkg::*;
;

  localparam int STR_LEN     = 32;
  localparam int RAND_BEATS  = 230;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 16;

  class neighbor_scoreboard;
    res_row_t    rows_due[$];
    res_row_t    step_rows[$];
    int unsigned errors, beats_seen, rows_seen, summaries_seen, truncations;

    logic [15:0] pos, flen, vlan_val;
    phase_e      walk_phase;
    logic [7:0]  hdr_hi, vlan_hi;
    logic [6:0]  cur_tlv;
    logic [8:0]  val_rem, val_off;
    logic [31:0] org;
    logic        vlan_seen, found, port_empty;

    function new();
      clear_frame();
    endfunction

    function void clear_frame();
      pos        = '0;
      flen       = '0;
      walk_phase = PH_SKIP;
      hdr_hi     = '0;
      cur_tlv    = '0;
      val_rem    = '0;
      val_off    = '0;
      org        = '0;
      vlan_hi    = '0;
      vlan_val   = '0;
      vlan_seen  = 1'b0;
      found      = 1'b0;
      port_empty = 1'b1;
    endfunction

    function void emit_char(target_e tgt, int idx, logic [7:0] val);
      res_row_t r;
      if (idx < STR_LEN - 1) begin
        r            = '0;
        r.kind       = KIND_WRITE;
        r.target     = tgt;
        r.char_index = 5'(idx);
        r.char_value = val;
        step_rows.push_back(r);
      end
    endfunction

    function void emit_len(target_e tgt, int n);
      res_row_t r;
      if (n > STR_LEN - 1) begin
        n = STR_LEN - 1;
        truncations++;
      end
      r            = '0;
      r.kind       = KIND_COMMIT;
      r.target     = tgt;
      r.str_length = 5'(n);
      step_rows.push_back(r);
    endfunction

    function void take_value(logic [7:0] b);
      int off, tot;
      bit is_last;
      off     = val_off;
      tot     = int'(val_off) + int'(val_rem);
      is_last = (val_rem == 9'd1);
      if (off < 4) org |= 32'(b) << (24 - 8 * off);
      case (cur_tlv)
        TLV_SYS_NAME: begin
          emit_char(TGT_HOST, off, b);
          if (is_last) begin
            emit_len(TGT_HOST, tot);
            found = 1'b1;
          end
        end
        TLV_PORT_ID: begin
          if (org[31:24] == PORT_SUBTYPE_LOCAL) begin
            // local subtype wipes the port on the subtype byte itself
            if (off == 0) begin
              emit_len(TGT_PORT, 0);
              port_empty = 1'b1;
            end
          end else begin
            if (off >= 1) emit_char(TGT_PORT, off - 1, b);
            if (is_last) begin
              emit_len(TGT_PORT, tot - 1);
              found      = 1'b1;
              port_empty = (tot - 1 == 0);
            end
          end
        end
        TLV_PORT_DESC: begin
          if (port_empty) begin
            emit_char(TGT_PORT, off, b);
            if (is_last) begin
              emit_len(TGT_PORT, tot);
              port_empty = 1'b0;
            end
          end
        end
        TLV_ORG: begin
          if (tot >= 4 && off >= 3) begin
            if (org == ORG_VLAN_ID) begin
              if (tot >= 6) begin
                if (off == 4) vlan_hi = b;
                if (off == 5) begin
                  vlan_val  = {vlan_hi, b};
                  vlan_seen = 1'b1;
                  found     = 1'b1;
                end
              end
            end else if (org == ORG_MED_HW) begin
              if (off >= 4) emit_char(TGT_PLAT, off - 4, b);
              if (is_last) begin
                emit_len(TGT_PLAT, tot - 4);
                found = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      val_off = 9'(off + 1);
      val_rem = val_rem - 9'd1;
      if (val_rem == 9'd0) walk_phase = PH_HI;
    endfunction

    function void take_header_low(logic [7:0] b);
      logic [6:0] tp;
      int         ln;
      tp       = hdr_hi[7:1];
      ln       = {hdr_hi[0], b};
      cur_tlv  = tp;
      if (int'(pos) + 1 + ln > int'(flen) || tp == TLV_END) begin
        walk_phase = PH_STOP;
      end else if (ln == 0) begin
        if (tp == TLV_SYS_NAME) begin
          emit_len(TGT_HOST, 0);
          found = 1'b1;
        end else if (tp == TLV_PORT_DESC && port_empty) begin
          emit_len(TGT_PORT, 0);
        end
        walk_phase = PH_HI;
      end else begin
        val_rem    = 9'(ln);
        val_off    = '0;
        org        = '0;
        walk_phase = PH_VAL;
      end
    endfunction

    function void note_input(in_beat_t beat);
      res_row_t r;
      int       p;
      beats_seen++;
      step_rows.delete();
      if (beat.frame_start) begin
        clear_frame();
        flen = beat.frame_len;
      end
      if (walk_phase != PH_IDLE) begin
        p = pos;
        if (p < int'(flen)) begin
          case (walk_phase)
            PH_SKIP: if (p >= 13) walk_phase = PH_HI;
            PH_HI: begin
              hdr_hi     = beat.data_byte;
              walk_phase = PH_LO;
            end
            PH_LO:  take_header_low(beat.data_byte);
            PH_VAL: take_value(beat.data_byte);
            default: ;
          endcase
        end
        if (p + 1 >= int'(flen)) begin
          r              = '0;
          r.kind         = KIND_SUMMARY;
          r.target       = TGT_HOST;
          r.vlan_id      = vlan_val;
          r.vlan_present = vlan_seen;
          r.valid_res    = found;
          step_rows.push_back(r);
          walk_phase = PH_IDLE;
        end else begin
          pos = 16'(p + 1);
        end
      end
      foreach (step_rows[i]) begin
        r             = step_rows[i];
        r.last_of_run = (i == step_rows.size() - 1);
        rows_due.push_back(r);
      end
    endfunction

    function void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", fname, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_row_t got);
      res_row_t want;
      rows_seen++;
      if (rows_due.size() == 0) begin
        $error("result row with nothing expected: kind %0d target %0d", got.kind, got.target);
        errors++;
      end else begin
        want = rows_due.pop_front();
        if (want.kind == KIND_SUMMARY) summaries_seen++;
        cmp_field("kind", want.kind, got.kind);
        cmp_field("target", want.target, got.target);
        cmp_field("char_index", want.char_index, got.char_index);
        cmp_field("char_value", want.char_value, got.char_value);
        cmp_field("str_length", want.str_length, got.str_length);
        cmp_field("vlan_id", want.vlan_id, got.vlan_id);
        cmp_field("vlan_present", want.vlan_present, got.vlan_present);
        cmp_field("valid_res", want.valid_res, got.valid_res);
        cmp_field("last_of_run", want.last_of_run, got.last_of_run);
      end
    endfunction

    function void check_drained();
      if (rows_due.size() != 0) begin
        $error("%0d expected result rows never arrived", rows_due.size());
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lldpx_in_if  in_bus ();
  lldpx_out_if res_bus ();

  lldp_tlv_neighbor_extractor #(
    .STRING_LEN(STR_LEN)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .res_o (res_bus)
  );

  neighbor_scoreboard sb;
  logic [7:0]  frame_q[$];
  bit          quiet;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;
  res_row_t    seen_row;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // accepted beats feed the predictor, accepted rows are checked
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready)
      sb.note_input('{data_byte: in_bus.data_byte, frame_len: in_bus.frame_len,
                      frame_start: in_bus.frame_start});
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      seen_row.kind         = kind_e'(res_bus.kind);
      seen_row.target       = target_e'(res_bus.target);
      seen_row.char_index   = res_bus.char_index;
      seen_row.char_value   = res_bus.char_value;
      seen_row.str_length   = res_bus.str_length;
      seen_row.vlan_id      = res_bus.vlan_id;
      seen_row.vlan_present = res_bus.vlan_present;
      seen_row.valid_res    = res_bus.valid_res;
      seen_row.last_of_run  = res_bus.last_of_run;
      sb.check_result(seen_row);
    end
  end

  // result side: random stall before each row
  initial begin
    int gap;
    res_bus.ready = 1'b0;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
        @(negedge clk_i);
        res_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_bus.valid && res_bus.ready));
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [15:0] flen, input logic st);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid       <= 1'b1;
    in_bus.data_byte   <= b;
    in_bus.frame_len   <= flen;
    in_bus.frame_start <= st;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
  endtask

  // frame_len only matters on the start beat, so other beats carry junk there
  task automatic send_frame(input int flen, input int nsend);
    for (int i = 0; i < nsend; i++)
      send_byte(frame_q[i], (i == 0) ? 16'(flen) : 16'($urandom), i == 0);
    bytes_sent += nsend;
  endtask

  function automatic void put_rand(int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void put_hdr(logic [6:0] tp, int ln);
    logic [8:0] l9;
    l9 = 9'(ln);
    frame_q.push_back({tp, l9[8]});
    frame_q.push_back(l9[7:0]);
  endfunction

  // org tlv: as much of the oui/subtype prefix as the length allows
  function automatic void put_org(logic [31:0] pfx, int ln);
    for (int i = 0; i < ln && i < 4; i++) frame_q.push_back(pfx[31 - 8 * i -: 8]);
    if (ln > 4) put_rand(ln - 4);
  endfunction

  function automatic void put_tlv();
    int pick, n, ln;
    pick = $urandom_range(0, 6);
    // mostly short strings, now and then one near or past the string capacity
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 36) : $urandom_range(0, 6);
    case (pick)
      0: begin
        put_hdr(TLV_SYS_NAME, n);
        put_rand(n);
      end
      1: begin
        put_hdr(TLV_PORT_ID, n);
        if (n > 0) begin
          frame_q.push_back(($urandom_range(0, 2) == 0) ? PORT_SUBTYPE_LOCAL
                                                         : 8'($urandom_range(1, 7)));
          put_rand(n - 1);
        end
      end
      2: begin
        put_hdr(TLV_PORT_DESC, n);
        put_rand(n);
      end
      3: begin
        ln = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : n + 4;
        put_hdr(TLV_ORG, ln);
        put_org(ORG_MED_HW, ln);
      end
      4: begin
        ln = $urandom_range(3, 8);
        put_hdr(TLV_ORG, ln);
        put_org(ORG_VLAN_ID, ln);
      end
      5: begin
        put_hdr(TLV_ORG, n + 4);
        put_rand(n + 4);
      end
      default: begin
        put_hdr(7'($urandom_range(1, 126)), n);
        put_rand(n);
      end
    endcase
  endfunction

  initial begin
    int mode, n;
    sb                 = new();
    quiet              = 1'b0;
    cycle_cnt          = 0;
    bytes_sent         = 0;
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.data_byte   = '0;
    in_bus.frame_len   = '0;
    in_bus.frame_start = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // a byte before any frame start, an empty frame, then a byte past its end
    send_byte(8'($urandom), 16'($urandom), 1'b0);
    send_byte(8'($urandom), 16'd0, 1'b1);
    send_byte(8'($urandom), 16'($urandom), 1'b0);

    // empty name, empty port id, one-byte port id, empty description on an
    // empty port, then a lone header byte before the frame end
    frame_q.delete();
    put_rand(14);
    put_hdr(TLV_SYS_NAME, 0);
    put_hdr(TLV_PORT_ID, 0);
    put_hdr(TLV_PORT_ID, 1);
    frame_q.push_back(8'h03);
    put_hdr(TLV_PORT_DESC, 0);
    put_rand(1);
    send_frame(frame_q.size(), frame_q.size());

    while (bytes_sent < RAND_BEATS) begin
      quiet = ($urandom_range(0, 3) == 0);
      frame_q.delete();
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        put_rand($urandom_range(1, 40));
        send_frame(frame_q.size(), frame_q.size());
      end else begin
        put_rand(14);
        repeat ($urandom_range(1, 4)) put_tlv();
        if ($urandom_range(0, 1)) begin
          put_hdr(TLV_END, 0);
          put_rand($urandom_range(0, 3));
        end
        n = frame_q.size();
        case (mode)
          // frame ends inside the tail, trailing beats fall past the end
          1: send_frame(n - $urandom_range(1, 4), n);
          2: begin
            put_rand(1);
            send_frame(n + 1, n + 1);
          end
          // long frame dropped by the next start
          3: send_frame(16'h8000 | $urandom_range(0, 16'h7fff), $urandom_range(15, n));
          default: send_frame(n, n);
        endcase
      end
    end
    quiet = 1'b0;
    @(negedge clk_i);
    in_bus.valid <= 1'b0;

    while (sb.rows_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    sb.check_drained();

    $display("fed %0d byte beats and checked %0d result rows", sb.beats_seen, sb.rows_seen);
    $display("%0d frame summaries, %0d strings cut to capacity", sb.summaries_seen,
             sb.truncations);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
